[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/scd_pkg.sv]
`timescale 1ns / 1ps

package scd_pkg;

  localparam int KEPT_BYTES = 4;
  localparam int KEPT_IDX_W = 2;

  localparam logic [7:0] ASCII_SLASH = 8'h2F;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;
  localparam logic [7:0] ASCII_A     = 8'h41;
  localparam logic [7:0] ASCII_B     = 8'h42;
  localparam logic [7:0] ASCII_C     = 8'h43;
  localparam logic [7:0] ASCII_D     = 8'h44;
  localparam logic [7:0] ASCII_E     = 8'h45;

  localparam logic [9:0]  OFFSET_RESET = 10'd100;
  localparam logic [10:0] PULSE_RESET  = 11'd100;
  localparam logic [9:0]  MAX_POSITION = 10'd999;

  localparam logic [6:0] SEG_A = 7'h77;
  localparam logic [6:0] SEG_B = 7'h7C;
  localparam logic [6:0] SEG_C = 7'h39;
  localparam logic [6:0] SEG_D = 7'h5E;
  localparam logic [6:0] SEG_E = 7'h79;

  localparam logic [6:0] SEG_DIGIT [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27, 7'h7F, 7'h6F
  };

  typedef struct packed {
    logic [6:0]  letter_segments;
    logic [6:0]  hundreds_segments;
    logic [6:0]  tens_segments;
    logic [6:0]  ones_segments;
    logic [9:0]  position;
    logic [10:0] pulse_a;
    logic [10:0] pulse_b;
    logic [10:0] pulse_c;
    logic        lamp_off;
    logic        digit_error;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
  endfunction

  // Non-digit bytes count as zero.
  function automatic logic [3:0] digit_value(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - ASCII_ZERO;
    return is_digit(b) ? diff[3:0] : 4'd0;
  endfunction

  function automatic logic [6:0] letter_segments(input logic [7:0] b);
    logic [6:0] seg;
    unique case (b)
      ASCII_A: seg = SEG_A;
      ASCII_B: seg = SEG_B;
      ASCII_C: seg = SEG_C;
      ASCII_D: seg = SEG_D;
      ASCII_E: seg = SEG_E;
      default: seg = 7'd0;
    endcase
    return seg;
  endfunction

endpackage

[rtl/scd_if.sv]
`timescale 1ns / 1ps

interface scd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scd_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] pulse_offset;
  modport source (output valid, output pulse_offset, input ready);
  modport sink   (input valid, input pulse_offset, output ready);
endinterface

interface scd_result_if import scd_pkg::*;;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/servo_command_decoder.sv]
`timescale 1ns / 1ps

// A byte accepted on rx is held in the input register, then decoded into the result register.
// Throughput: one item per cycle while result is not stalled; the decode and pulse add fit between the two registers.
// rx.ready drops only while both stages hold items and result is stalled.
// cfg writes are taken every cycle.
// Synchronous reset: buffer and write index to 0, pulses and offset to 100, lamp flag to 0.
module servo_command_decoder import scd_pkg::*; #(
  parameter int BUFFER_LEN = 10
) (
  input logic           clk,
  input logic           rst,
  scd_cfg_if.sink       cfg,
  scd_rx_if.sink        rx,
  scd_result_if.source  result
);

  localparam int PosW = $clog2(BUFFER_LEN);
  localparam logic [PosW-1:0] LastPos   = PosW'(BUFFER_LEN - 1);
  localparam logic [PosW-1:0] KeptLimit = PosW'(KEPT_BYTES);

  logic            s1_valid;
  logic [7:0]      s1_byte;
  logic            s1_advance;
  logic            out_valid;
  result_t         out_payload;

  logic [9:0]      offset;
  logic [7:0]      cmd [KEPT_BYTES];
  logic [7:0]      cmd_next [KEPT_BYTES];
  logic [PosW-1:0] write_position;
  logic [PosW-1:0] write_position_next;
  logic [10:0]     pulse [3];
  logic [10:0]     pulse_next [3];
  logic            lamp;
  logic            lamp_next;

  logic [3:0]      d_h, d_t, d_o;
  logic [9:0]      pos;
  logic [10:0]     pulse_new;
  logic [7:0]      letter;
  logic            bad;
  result_t         payload_next;

  assign s1_advance   = s1_valid && (!out_valid || result.ready);
  assign rx.ready     = !s1_valid || s1_advance;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.payload = out_payload;

  always_comb begin
    for (int i = 0; i < KEPT_BYTES; i++) begin
      cmd_next[i] = cmd[i];
    end
    if (write_position < KeptLimit) begin
      cmd_next[write_position[KEPT_IDX_W-1:0]] = s1_byte;
    end
    if (s1_byte == ASCII_SLASH || write_position >= LastPos) begin
      write_position_next = '0;
    end else begin
      write_position_next = write_position + 1'b1;
    end

    letter = cmd_next[0];
    d_h = digit_value(cmd_next[1]);
    d_t = digit_value(cmd_next[2]);
    d_o = digit_value(cmd_next[3]);
    bad = !is_digit(cmd_next[1]) || !is_digit(cmd_next[2]) || !is_digit(cmd_next[3]);
    pos = 10'(d_h) * 10'd100 + 10'(d_t) * 10'd10 + 10'(d_o);
    pulse_new = 11'(pos) + 11'(offset);

    for (int i = 0; i < 3; i++) begin
      pulse_next[i] = pulse[i];
    end
    lamp_next = lamp;
    unique case (letter)
      ASCII_A: begin
        pulse_next[0] = pulse_new;
        lamp_next     = 1'b0;
      end
      ASCII_B: pulse_next[1] = pulse_new;
      ASCII_C: pulse_next[2] = pulse_new;
      default: lamp_next = 1'b1;
    endcase

    payload_next.letter_segments   = letter_segments(letter);
    payload_next.hundreds_segments = SEG_DIGIT[d_h];
    payload_next.tens_segments     = SEG_DIGIT[d_t];
    payload_next.ones_segments     = SEG_DIGIT[d_o];
    payload_next.position          = pos;
    payload_next.pulse_a           = pulse_next[0];
    payload_next.pulse_b           = pulse_next[1];
    payload_next.pulse_c           = pulse_next[2];
    payload_next.lamp_off          = lamp_next;
    payload_next.digit_error       = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      offset         <= OFFSET_RESET;
      write_position <= '0;
      lamp           <= 1'b0;
      for (int i = 0; i < KEPT_BYTES; i++) begin
        cmd[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        pulse[i] <= PULSE_RESET;
      end
    end else begin
      if (cfg.valid) begin
        offset <= cfg.pulse_offset;
      end
      if (rx.valid && rx.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid      <= 1'b1;
        write_position <= write_position_next;
        lamp           <= lamp_next;
        for (int i = 0; i < KEPT_BYTES; i++) begin
          cmd[i] <= cmd_next[i];
        end
        for (int i = 0; i < 3; i++) begin
          pulse[i] <= pulse_next[i];
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
    if (s1_advance) begin
      out_payload <= payload_next;
    end
  end

endmodule

[rtl/scd_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module scd_checker import scd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_payload
);

  `SCD_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
  `SCD_ASSERT_NOW(a_position_range, out_valid, out_payload.position <= MAX_POSITION)
  `SCD_ASSERT_NOW(a_bad_digit_zero, out_valid && out_payload.digit_error, (out_payload.hundreds_segments == SEG_DIGIT[0]) || (out_payload.tens_segments == SEG_DIGIT[0]) || (out_payload.ones_segments == SEG_DIGIT[0]))
  `SCD_ASSERT_NOW(a_lamp_a_on, out_valid && (out_payload.letter_segments == SEG_A), !out_payload.lamp_off)
  `SCD_ASSERT_NOW(a_lamp_de_off, out_valid && ((out_payload.letter_segments == SEG_D) || (out_payload.letter_segments == SEG_E)), out_payload.lamp_off)

endmodule

bind servo_command_decoder scd_checker u_scd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_payload (result.payload)
);

[dv/tb_servo_command_decoder.sv]
`timescale 1ns / 1ps

module tb_servo_command_decoder;
  import scd_pkg::*;

  localparam int BUF_LEN = 10;
  localparam int ITEM_TARGET = 850;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 6;

  class servo_scoreboard;
    logic [7:0]  cmd_bytes [KEPT_BYTES];
    logic [3:0]  wr_pos;
    logic [10:0] pulse [3];
    logic        lamp;
    logic [9:0]  offset;
    result_t     expected_q [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      foreach (cmd_bytes[i]) cmd_bytes[i] = '0;
      foreach (pulse[i]) pulse[i] = PULSE_RESET;
      wr_pos = '0;
      lamp = 1'b0;
      offset = OFFSET_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function void set_offset(logic [9:0] v);
      offset = v;
    endfunction

    function void note_byte(logic [7:0] b);
      result_t    r;
      logic [3:0] d [3];
      logic       bad;
      logic [9:0] pos;
      logic [7:0] letter;
      bad = 1'b0;
      if (wr_pos < KEPT_BYTES) cmd_bytes[wr_pos[KEPT_IDX_W-1:0]] = b;
      if (b == ASCII_SLASH || wr_pos >= BUF_LEN - 1) wr_pos = '0;
      else wr_pos = wr_pos + 4'd1;
      for (int i = 0; i < 3; i++) begin
        if (cmd_bytes[i+1] >= ASCII_ZERO && cmd_bytes[i+1] <= ASCII_NINE) begin
          d[i] = 4'(cmd_bytes[i+1] - ASCII_ZERO);
        end else begin
          d[i] = '0;
          bad = 1'b1;
        end
      end
      pos = 10'(d[0] * 100 + d[1] * 10 + d[2]);
      letter = cmd_bytes[0];
      if (letter >= ASCII_A && letter <= ASCII_C) begin
        pulse[letter - ASCII_A] = {1'b0, pos} + {1'b0, offset};
      end
      if (letter == ASCII_A) lamp = 1'b0;
      else if (letter != ASCII_B && letter != ASCII_C) lamp = 1'b1;
      case (letter)
        ASCII_A: r.letter_segments = SEG_A;
        ASCII_B: r.letter_segments = SEG_B;
        ASCII_C: r.letter_segments = SEG_C;
        ASCII_D: r.letter_segments = SEG_D;
        ASCII_E: r.letter_segments = SEG_E;
        default: r.letter_segments = '0;
      endcase
      r.hundreds_segments = SEG_DIGIT[d[0]];
      r.tens_segments = SEG_DIGIT[d[1]];
      r.ones_segments = SEG_DIGIT[d[2]];
      r.position = pos;
      r.pulse_a = pulse[0];
      r.pulse_b = pulse[1];
      r.pulse_c = pulse[2];
      r.lamp_off = lamp;
      r.digit_error = bad;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [10:0] want, logic [10:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result item with nothing expected: %0h", got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("letter_segments", want.letter_segments, got.letter_segments);
      compare_field("hundreds_segments", want.hundreds_segments, got.hundreds_segments);
      compare_field("tens_segments", want.tens_segments, got.tens_segments);
      compare_field("ones_segments", want.ones_segments, got.ones_segments);
      compare_field("position", want.position, got.position);
      compare_field("pulse_a", want.pulse_a, got.pulse_a);
      compare_field("pulse_b", want.pulse_b, got.pulse_b);
      compare_field("pulse_c", want.pulse_c, got.pulse_c);
      compare_field("lamp_off", want.lamp_off, got.lamp_off);
      compare_field("digit_error", want.digit_error, got.digit_error);
    endfunction

    function int unsigned waiting();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  scd_rx_if     rx_if ();
  scd_cfg_if    cfg_if ();
  scd_result_if res_if ();

  servo_scoreboard sb;
  int unsigned     bytes_sent;
  int unsigned     offsets_written;
  bit              tx_steady;
  bit              rx_steady;
  bit              hold_req;

  servo_command_decoder #(.BUFFER_LEN(BUF_LEN)) uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .rx     (rx_if),
    .result (res_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) sb.check_result(res_if.payload);
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 7) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic pause_tx(int unsigned n);
    @(negedge clk);
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    sb.note_byte(b);
    bytes_sent++;
    if (!tx_steady && $urandom_range(0, 3) == 0) pause_tx(pick_gap());
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    pause_tx(1);
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(logic [9:0] v);
    wait_drained();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.pulse_offset <= v;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_offset(v);
    offsets_written++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // well-formed commands most of the time, then short, overlong and noise
  task automatic send_random_command();
    int unsigned kind;
    int unsigned n_digits;
    logic [7:0]  letter;
    kind = $urandom_range(0, 99);
    if (kind >= 93) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: letter = ASCII_A + 8'($urandom_range(0, 2));
      6: letter = ASCII_D;
      7: letter = ASCII_E;
      8: letter = 8'($urandom_range(8'h41, 8'h7A));
      default: letter = 8'($urandom);
    endcase
    send_byte(letter);
    n_digits = (kind >= 75 && kind < 85) ? $urandom_range(0, 2) : 3;
    repeat (n_digits) begin
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
      else send_byte(ASCII_ZERO + 8'($urandom_range(0, 9)));
    end
    if (kind >= 85) repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
    send_byte(ASCII_SLASH);
  endtask

  initial begin : stimulus
    logic [9:0] phase_offset;
    int         phase;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.pulse_offset = '0;
    res_if.ready = 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    offsets_written = 0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text("A000/");
    send_text("B999/");
    // non-digits in digit places, extreme byte values
    send_byte(ASCII_C);
    send_byte(8'h00);
    send_byte(ASCII_ZERO + 8'd7);
    send_byte(8'hFF);
    send_byte(ASCII_SLASH);
    send_byte(ASCII_SLASH);
    send_text("E1/");
    // lower-case letter, no terminator: index wraps after the last slot
    send_text("d123456789");

    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case (phase)
        0: phase_offset = '0;
        1: phase_offset = 10'h3FF;
        default: phase_offset = 10'($urandom);
      endcase
      write_offset(phase_offset);
      tx_steady = (phase % 3 == 2);
      rx_steady = tx_steady;
      if (phase == 1) send_text("A999/");
      if (phase == 3) begin
        hold_req = 1'b1;
        tx_steady = 1'b1;
        repeat (5) send_random_command();
        tx_steady = 1'b0;
      end
      repeat (25) if (bytes_sent < ITEM_TARGET) send_random_command();
      phase++;
    end
    wait_drained();

    $display("run covered %0d bytes under %0d offset settings, %0d results checked",
             bytes_sent, offsets_written + 1, sb.checked);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
